FILE: rtl/ufp_pkg.sv
// Package of constants, types and helper functions for the UDP fragment frame parser.
package ufp_pkg;

  localparam int PayloadBytes      = 1024;
  localparam int FragmentsPerBatch = 256;
  localparam int HdrAt             = 42;
  localparam int HdrBytes          = 38;
  localparam int CapBytes          = 80;
  localparam int FrameBytes        = CapBytes + PayloadBytes;
  localparam int CntW              = $clog2(FrameBytes + 2);
  localparam int SlotShift         = $clog2(FragmentsPerBatch);

  localparam logic [31:0] CrcPoly = 32'h82f63b78;
  localparam logic [31:0] HdrMagic = 32'h44515249;

  localparam logic [CntW-1:0] FrameLen  = CntW'(FrameBytes);
  localparam logic [CntW-1:0] CntSat    = CntW'(FrameBytes + 1);
  localparam logic [CntW-1:0] HdrFirst  = CntW'(HdrAt);
  localparam logic [CntW-1:0] CrcFirst  = CntW'(HdrAt + 30);
  localparam logic [CntW-1:0] CrcLast   = CntW'(HdrAt + 33);
  localparam logic [CntW-1:0] HdrLast   = CntW'(HdrAt + HdrBytes - 1);

  localparam logic [0:0] CfgCheckEpoch    = 1'd0;
  localparam logic [0:0] CfgExpectedEpoch = 1'd1;

  typedef enum logic [4:0] {
    ST_OK        = 5'd0,
    ST_TRUNC     = 5'd1,
    ST_LENGTH    = 5'd2,
    ST_ETHERTYPE = 5'd3,
    ST_IPV4_HDR  = 5'd4,
    ST_FRAG      = 5'd5,
    ST_IP_LEN    = 5'd6,
    ST_NOT_UDP   = 5'd7,
    ST_UDP_LEN   = 5'd8,
    ST_MAGIC     = 5'd9,
    ST_VERSION   = 5'd10,
    ST_FLAGS     = 5'd11,
    ST_HDR_LEN   = 5'd12,
    ST_CRC       = 5'd13,
    ST_RESERVED  = 5'd14,
    ST_SLOT      = 5'd15,
    ST_ZERO_EP   = 5'd16,
    ST_EPOCH     = 5'd17,
    ST_PLEN      = 5'd18,
    ST_COUNT     = 5'd19,
    ST_SEQUENCE  = 5'd20
  } status_t;

  // Per-check failure flags, gathered as the bytes go past.
  typedef struct packed {
    logic ethertype;
    logic ipv4_hdr;
    logic frag;
    logic ip_len;
    logic not_udp;
    logic udp_len;
    logic magic;
    logic version;
    logic flags;
    logic hdr_len;
    logic reserved;
  } fails_t;

  // One frame's captured header, handed to the result stage.
  typedef struct packed {
    logic [CntW-1:0] count;
    fails_t          fails;
    logic [31:0]     crc_calc;
    logic [31:0]     crc_field;
    logic [15:0]     slot;
    logic [31:0]     batch;
    logic [63:0]     epoch;
    logic [31:0]     seq;
    logic [15:0]     plen;
    logic [15:0]     fcnt;
  } frame_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] v;
    v = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      v = v[0] ? ((v >> 1) ^ CrcPoly) : (v >> 1);
    end
    return v;
  endfunction

endpackage

FILE: rtl/ufp_scan.sv
// Byte scanner: counts bytes, runs the header CRC and captures the frame fields.
module ufp_scan (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  take,
  input  logic [7:0]            data_byte,
  input  logic                  last_byte,
  output ufp_pkg::frame_t       frame
);
  import ufp_pkg::*;

  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [31:0]     crc_r, crc_nxt;
  fails_t          fails_r, fails_nxt;
  logic [31:0]     crcf_r, crcf_nxt;
  logic [15:0]     slot_r, slot_nxt, plen_r, plen_nxt, fcnt_r, fcnt_nxt;
  logic [31:0]     batch_r, batch_nxt, seq_r, seq_nxt;
  logic [63:0]     epoch_r, epoch_nxt;
  logic [7:0]      b;
  logic [7:0]      prev_r;

  assign b = data_byte;

  // Two-byte fields compare against the previous byte, which is held in prev_r.
  always_comb begin
    logic [6:0] p;
    p = (cnt_r < CntW'(CapBytes)) ? cnt_r[6:0] : 7'd127;
    cnt_nxt   = (cnt_r < CntSat) ? cnt_r + 1'b1 : cnt_r;
    crc_nxt   = crc_r;
    fails_nxt = fails_r;
    crcf_nxt  = crcf_r;
    slot_nxt  = slot_r;
    batch_nxt = batch_r;
    epoch_nxt = epoch_r;
    seq_nxt   = seq_r;
    plen_nxt  = plen_r;
    fcnt_nxt  = fcnt_r;
    if (cnt_r >= HdrFirst && cnt_r <= HdrLast) begin
      crc_nxt = crc_byte(crc_r, (cnt_r >= CrcFirst && cnt_r <= CrcLast) ? 8'd0 : b);
    end
    case (p)
      7'd13: fails_nxt.ethertype = ({prev_r, b} != 16'h0800);
      7'd14: fails_nxt.ipv4_hdr  = (b != 8'h45);
      7'd17: fails_nxt.ip_len    = ({prev_r, b} != 16'(FrameBytes - 14));
      7'd21: fails_nxt.frag      = (({prev_r, b} & 16'h3fff) != 16'd0);
      7'd23: fails_nxt.not_udp   = (b != 8'd17);
      7'd39: fails_nxt.udp_len   = ({prev_r, b} != 16'(FrameBytes - 34));
      7'd42: fails_nxt.magic     = (b != HdrMagic[31:24]);
      7'd43: fails_nxt.magic     = fails_r.magic | (b != HdrMagic[23:16]);
      7'd44: fails_nxt.magic     = fails_r.magic | (b != HdrMagic[15:8]);
      7'd45: fails_nxt.magic     = fails_r.magic | (b != HdrMagic[7:0]);
      7'd46: fails_nxt.version   = (b != 8'd1);
      7'd47: fails_nxt.flags     = (b != 8'd0);
      7'd49: fails_nxt.hdr_len   = ({prev_r, b} != 16'(HdrBytes));
      7'd50, 7'd51: slot_nxt = {slot_r[7:0], b};
      7'd52, 7'd53, 7'd54, 7'd55: batch_nxt = {batch_r[23:0], b};
      7'd56, 7'd57, 7'd58, 7'd59, 7'd60, 7'd61, 7'd62, 7'd63: epoch_nxt = {epoch_r[55:0], b};
      7'd64, 7'd65, 7'd66, 7'd67: seq_nxt = {seq_r[23:0], b};
      7'd68, 7'd69: plen_nxt = {plen_r[7:0], b};
      7'd70, 7'd71: fcnt_nxt = {fcnt_r[7:0], b};
      7'd72, 7'd73, 7'd74, 7'd75: crcf_nxt = {crcf_r[23:0], b};
      7'd76: fails_nxt.reserved  = (b != 8'd0);
      7'd77, 7'd78, 7'd79: fails_nxt.reserved = fails_r.reserved | (b != 8'd0);
      default: ;
    endcase
  end

  // The frame as it stands once this byte is included.
  always_comb begin
    frame.count     = cnt_nxt;
    frame.fails     = fails_nxt;
    frame.crc_calc  = ~crc_nxt;
    frame.crc_field = crcf_nxt;
    frame.slot      = slot_nxt;
    frame.batch     = batch_nxt;
    frame.epoch     = epoch_nxt;
    frame.seq       = seq_nxt;
    frame.plen      = plen_nxt;
    frame.fcnt      = fcnt_nxt;
  end

  // A frame never reaching a check leaves its flag clear, matching an all-zero capture.
  always_ff @(posedge clk) begin
    if (!rst_n || (take && last_byte)) begin
      cnt_r   <= '0;
      crc_r   <= '1;
      fails_r <= '0;
      crcf_r  <= '0;
      slot_r  <= '0;
      batch_r <= '0;
      epoch_r <= '0;
      seq_r   <= '0;
      plen_r  <= '0;
      fcnt_r  <= '0;
      prev_r  <= '0;
    end else if (take) begin
      cnt_r   <= cnt_nxt;
      crc_r   <= crc_nxt;
      fails_r <= fails_nxt;
      crcf_r  <= crcf_nxt;
      slot_r  <= slot_nxt;
      batch_r <= batch_nxt;
      epoch_r <= epoch_nxt;
      seq_r   <= seq_nxt;
      plen_r  <= plen_nxt;
      fcnt_r  <= fcnt_nxt;
      prev_r  <= b;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_sat: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= CntSat)
    else $error("byte count beyond saturation");
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
      take && last_byte |=> cnt_r == '0 && crc_r == '1)
    else $error("frame state not cleared after last byte");
  a_step: assert property (@(posedge clk) disable iff (!rst_n)
      take && !last_byte && $past(rst_n) && cnt_r < CntSat |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("byte count did not advance");
`endif

endmodule

FILE: rtl/ufp_judge.sv
// Result stage: picks the first failing check and registers the result request.
module ufp_judge (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  ufp_pkg::frame_t       frame,
  input  logic                  check_epoch,
  input  logic [63:0]           expected_epoch,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [4:0]            out_status,
  output logic [15:0]           out_slot,
  output logic [31:0]           out_batch,
  output logic [63:0]           out_epoch,
  output logic [31:0]           out_sequence_res,
  output logic [15:0]           out_payload_length,
  output logic [15:0]           out_fragment_count
);
  import ufp_pkg::*;

  status_t     st;
  logic [31:0] seq_calc;
  logic        valid_r;
  status_t     st_r;
  logic [15:0] slot_r, plen_r, fcnt_r;
  logic [31:0] batch_r, seq_r;
  logic [63:0] epoch_r;

  // Multiplying by the fragments per batch is a shift for a power of two.
  assign seq_calc = (FragmentsPerBatch == (1 << SlotShift)) ?
                    ((frame.batch << SlotShift) + {16'd0, frame.slot}) :
                    (frame.batch * 32'(FragmentsPerBatch) + {16'd0, frame.slot});

  always_comb begin
    if (frame.count < FrameLen)                 st = ST_TRUNC;
    else if (frame.count != FrameLen)           st = ST_LENGTH;
    else if (frame.fails.ethertype)             st = ST_ETHERTYPE;
    else if (frame.fails.ipv4_hdr)              st = ST_IPV4_HDR;
    else if (frame.fails.frag)                  st = ST_FRAG;
    else if (frame.fails.ip_len)                st = ST_IP_LEN;
    else if (frame.fails.not_udp)               st = ST_NOT_UDP;
    else if (frame.fails.udp_len)               st = ST_UDP_LEN;
    else if (frame.fails.magic)                 st = ST_MAGIC;
    else if (frame.fails.version)               st = ST_VERSION;
    else if (frame.fails.flags)                 st = ST_FLAGS;
    else if (frame.fails.hdr_len)               st = ST_HDR_LEN;
    else if (frame.crc_field != frame.crc_calc) st = ST_CRC;
    else if (frame.fails.reserved)              st = ST_RESERVED;
    else if (frame.slot >= 16'(FragmentsPerBatch)) st = ST_SLOT;
    else if (frame.epoch == 64'd0)              st = ST_ZERO_EP;
    else if (check_epoch && frame.epoch != expected_epoch) st = ST_EPOCH;
    else if (frame.plen != 16'(PayloadBytes))   st = ST_PLEN;
    else if (frame.fcnt != 16'(FragmentsPerBatch)) st = ST_COUNT;
    else if (frame.seq != seq_calc)             st = ST_SEQUENCE;
    else                                        st = ST_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      st_r <= st;
      // Envelope failures report no header fields.
      if (st >= ST_TRUNC && st <= ST_UDP_LEN) begin
        slot_r  <= '0;
        batch_r <= '0;
        epoch_r <= '0;
        seq_r   <= '0;
        plen_r  <= '0;
        fcnt_r  <= '0;
      end else begin
        slot_r  <= frame.slot;
        batch_r <= frame.batch;
        epoch_r <= frame.epoch;
        seq_r   <= frame.seq;
        plen_r  <= frame.plen;
        fcnt_r  <= frame.fcnt;
      end
    end
  end

  assign out_valid          = valid_r;
  assign out_status         = st_r;
  assign out_slot           = slot_r;
  assign out_batch          = batch_r;
  assign out_epoch          = epoch_r;
  assign out_sequence_res   = seq_r;
  assign out_payload_length = plen_r;
  assign out_fragment_count = fcnt_r;

`ifndef ASSERT_OFF
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && !out_ready && !load |=> out_valid && $stable(st_r))
    else $error("result request changed while stalled");
  a_env_zero: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && st_r >= ST_TRUNC && st_r <= ST_UDP_LEN |-> slot_r == '0 && epoch_r == '0)
    else $error("envelope failure carries header fields");
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid |-> st_r <= ST_SEQUENCE)
    else $error("status out of range");
`endif

endmodule

FILE: rtl/udp_fragment_header_frame_parser.sv
// Top level of the UDP fragment header frame parser.
// Takes an Ethernet frame one byte per request, with last_byte marking the final byte, and
// returns one result request per frame: the first failing check in status code order and the
// decoded header fields. A byte is accepted every cycle; the result appears in the cycle after the
// last byte and is held in an output register, so the next frame's bytes keep flowing while it
// waits. Throughput is set by the single CRC-32C byte step per cycle in the scanner. Input is
// stalled only when a result is waiting and another last byte arrives.
module udp_fragment_header_frame_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_status,
  output logic [15:0] out_slot,
  output logic [31:0] out_batch,
  output logic [63:0] out_epoch,
  output logic [31:0] out_sequence_res,
  output logic [15:0] out_payload_length,
  output logic [15:0] out_fragment_count,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import ufp_pkg::*;

  logic        take;
  logic        check_epoch_r;
  logic [63:0] expected_epoch_r;
  frame_t      frame;

  // A last byte can only land once the output register is free or being emptied.
  assign in_ready = !in_last_byte || !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      check_epoch_r    <= 1'b0;
      expected_epoch_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgCheckEpoch:    check_epoch_r    <= cfg_data[0];
        CfgExpectedEpoch: expected_epoch_r <= cfg_data;
        default: ;
      endcase
    end
  end

  ufp_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .frame     (frame)
  );

  ufp_judge u_judge (
    .clk                (clk),
    .rst_n              (rst_n),
    .load               (take && in_last_byte),
    .frame              (frame),
    .check_epoch        (check_epoch_r),
    .expected_epoch     (expected_epoch_r),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_slot           (out_slot),
    .out_batch          (out_batch),
    .out_epoch          (out_epoch),
    .out_sequence_res   (out_sequence_res),
    .out_payload_length (out_payload_length),
    .out_fragment_count (out_fragment_count)
  );

`ifndef ASSERT_OFF
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
      take && in_last_byte |-> !out_valid || out_ready)
    else $error("result overwritten before it was taken");
  a_body_flow: assert property (@(posedge clk) disable iff (!rst_n)
      in_valid && !in_last_byte |-> in_ready)
    else $error("frame body stalled");
  a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
      cfg_we && cfg_index == CfgExpectedEpoch |=> expected_epoch_r == $past(cfg_data))
    else $error("expected epoch not written");
`endif

endmodule
